@@ design/dfs_pkg.sv @@
// Package: shared types, constants and sequencer states for the depth-first search block
package dfs_pkg;
  localparam int MaxVertices = 64;
  localparam int RowWidth = 64;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRun = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  row_index;
    logic [63:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [5:0] vertex;
    logic [7:0] discover_time;
    logic [7:0] finish_time;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_TOP_RD,
    ST_ROW_RD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;
endpackage

@@ design/dfs_adj_mem.sv @@
// Adjacency matrix memory: one row per vertex, synchronous read
module dfs_adj_mem
  import dfs_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [RowWidth-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [RowWidth-1:0] rdata
);
  logic [RowWidth-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/dfs_stamp_mem.sv @@
// Stamp memory: discovery and finish times per vertex, two write ports by field, one read
module dfs_stamp_mem
  import dfs_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices,
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  logic          clk,
  input  logic          we_d,
  input  logic          we_f,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_d,
  output logic [7:0]    rdata_f
);
  logic [7:0] dmem [MAX_VERTICES];
  logic [7:0] fmem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we_d) begin
      dmem[waddr] <= wdata;
    end
    if (we_f) begin
      fmem[waddr] <= wdata;
    end
    rdata_d <= dmem[raddr];
    rdata_f <= fmem[raddr];
  end
endmodule

@@ design/dfs_discover_finish_times_top.sv @@
// Top level: depth-first search discovery and finish time stamping
//
// Input channel (in_valid/in_ready, in_item) carries load and run items.
// A load item writes one adjacency row.
// A run item clears the visited marks in its accept cycle, walks every vertex
// in ascending order with an explicit stack, then sends one output item per
// vertex on out_valid/out_ready, the last one flagged.
// The run is bounded by the neighbour scan: each time a vertex is on top of
// the stack one row is read and columns are scanned one per cycle from column 0.
// Input is taken only while no run is in progress.
// Output items leave from a register; a stalled receiver holds the item and
// the sequencer waits. vertex_count is written through cfg_we/cfg_data.
// Reset clears the adjacency matrix by a pass over every row, sets
// vertex_count to 1 and takes no item during the pass.
module dfs_discover_finish_times_top
  import dfs_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data
);
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t state, state_next;
  logic [6:0]    vertex_count;
  logic [CW-1:0] n;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] root, root_next;
  logic [CW-1:0] depth, depth_next;
  logic [CW-1:0] col, col_next;
  logic [AW-1:0] top, top_next;
  logic [7:0]    tcount, tcount_next;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] cand;
  logic [AW-1:0] stack [MAX_VERTICES];
  logic [AW-1:0] stack_q;
  logic          popped;
  logic [AW-1:0] stack_rd;
  logic          clearing;
  logic [CW-1:0] clr_idx;

  logic                adj_we;
  logic [AW-1:0]       adj_waddr, adj_raddr;
  logic [RowWidth-1:0] adj_wdata, adj_rdata;
  logic                st_we_d, st_we_f;
  logic [AW-1:0]       st_waddr, st_raddr;
  logic [7:0]          st_rdata_d, st_rdata_f;
  logic                push, pop, set_gray, run_start;
  logic [AW-1:0]       push_v;
  logic                out_load;

  always_comb begin
    if (vertex_count == 7'd0) begin
      n = CW'(1);
    end else if ({1'b0, vertex_count} > 8'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vertex_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd1;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == CW'(MAX_VERTICES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ST_IDLE) && !clearing;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = in_item.row_index[AW-1:0];
    adj_wdata = in_item.row_bits;
    if (clearing) begin
      adj_we    = 1'b1;
      adj_waddr = clr_idx[AW-1:0];
      adj_wdata = '0;
    end else if (in_valid && in_ready && in_item.cmd == CmdLoad &&
                 {1'b0, in_item.row_index} < 7'(MAX_VERTICES)) begin
      adj_we = 1'b1;
    end
  end

  assign adj_raddr = stack_rd;
  assign cand = adj_rdata[MAX_VERTICES-1:0] & ~visited;

  dfs_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  dfs_stamp_mem #(.MAX_VERTICES(MAX_VERTICES)) u_stamp (
    .clk(clk), .we_d(st_we_d), .we_f(st_we_f), .waddr(st_waddr),
    .wdata(tcount_next), .raddr(st_raddr), .rdata_d(st_rdata_d), .rdata_f(st_rdata_f)
  );

  always_ff @(posedge clk) begin
    stack_rd <= top_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    root_next   = root;
    depth_next  = depth;
    col_next    = col;
    top_next    = top;
    tcount_next = tcount;
    push = 1'b0; pop = 1'b0; set_gray = 1'b0; run_start = 1'b0;
    push_v   = root[AW-1:0];
    st_we_d  = 1'b0;
    st_we_f  = 1'b0;
    st_waddr = root[AW-1:0];
    st_raddr = idx[AW-1:0];
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready && in_item.cmd == CmdRun) begin
          run_start   = 1'b1;
          state_next  = ST_ROOT;
          idx_next    = '0;
          tcount_next = '0;
          depth_next  = '0;
          root_next   = '0;
        end
      end
      ST_ROOT: begin
        if (root == n) begin
          state_next = ST_EMIT_RD;
          idx_next   = '0;
        end else if (!visited[root[AW-1:0]]) begin
          push = 1'b1; set_gray = 1'b1; push_v = root[AW-1:0];
          tcount_next = tcount + 1'b1;
          st_we_d  = 1'b1;
          st_waddr = root[AW-1:0];
          depth_next = depth + 1'b1;
          top_next   = root[AW-1:0];
          state_next = ST_TOP_RD;
        end else begin
          root_next = root + 1'b1;
        end
      end
      ST_TOP_RD: begin
        if (popped) begin
          top_next = stack_q;
        end
        state_next = ST_ROW_RD;
      end
      ST_ROW_RD: begin
        col_next   = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (col == n) begin
          tcount_next = tcount + 1'b1;
          st_we_f  = 1'b1;
          st_waddr = top;
          pop = 1'b1;
          depth_next = depth - 1'b1;
          if (depth == CW'(1)) begin
            root_next  = root + 1'b1;
            state_next = ST_ROOT;
          end else begin
            state_next = ST_TOP_RD;
          end
        end else if (cand[col[AW-1:0]]) begin
          push = 1'b1; set_gray = 1'b1; push_v = col[AW-1:0];
          tcount_next = tcount + 1'b1;
          st_we_d  = 1'b1;
          st_waddr = col[AW-1:0];
          depth_next = depth + 1'b1;
          top_next   = col[AW-1:0];
          state_next = ST_TOP_RD;
        end else begin
          col_next = col + 1'b1;
        end
      end
      ST_EMIT_RD: begin
        if (!out_valid || out_ready) begin
          st_raddr   = idx[AW-1:0];
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_load = 1'b1;
        idx_next = idx + 1'b1;
        if (idx + 1'b1 == n) begin
          state_next = ST_IDLE;
        end else begin
          st_raddr   = idx_next[AW-1:0];
          state_next = ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    idx    <= idx_next;
    root   <= root_next;
    depth  <= depth_next;
    col    <= col_next;
    top    <= top_next;
    tcount <= tcount_next;
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      visited <= '0;
    end else if (set_gray) begin
      visited[push_v] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack[depth[AW-1:0]] <= push_v;
    end
    stack_q <= stack[depth[AW-1:0] - AW'(2)];
    popped  <= pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_item.vertex        <= idx[5:0];
      out_item.discover_time <= st_rdata_d;
      out_item.finish_time   <= st_rdata_f;
      out_item.last          <= (idx + 1'b1 == n);
    end
  end
endmodule
